FILE: rtl/core/swrl_pkg.sv
`timescale 1ns / 1ps
package swrl_pkg;

	localparam int SWRL_HISTORY_DEPTH = 8;
	localparam int BYTES_W = 17;
	localparam int TIME_W = 32;
	localparam int PAYLOAD_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam logic [BYTES_W-1:0] HEADER_BYTES = 17'd34;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = 1'b1;

	// item operation codes
	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_RECORD = 1'b1;

	typedef struct packed {
		logic capture;
		logic write_rec;
		logic scan_clear;
		logic scan_read;
		logic div_start;
		logic div_step;
		logic out_load;
	} swrl_cmd_t;

	typedef struct packed {
		logic is_record;
		logic bypass;
		logic scan_last;
		logic div_last;
		logic out_free;
	} swrl_status_t;

endpackage

FILE: rtl/core/swrl_ram.sv
`timescale 1ns / 1ps
module swrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/swrl_ctrl.sv
`timescale 1ns / 1ps
module swrl_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  swrl_pkg::swrl_status_t status,
	output swrl_pkg::swrl_cmd_t    cmd
);

	import swrl_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_EXEC   = 7'b0000010,
		ST_SCAN   = 7'b0000100,
		ST_DRAIN  = 7'b0001000,
		ST_DSTART = 7'b0010000,
		ST_DIV    = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.is_record) begin
					cmd.write_rec = 1'b1;
					state_d = ST_IDLE;
				end else if (status.bypass) begin
					state_d = ST_DONE;
				end else begin
					cmd.scan_clear = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_read = 1'b1;
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			// last slot read lands in the accumulators here
			ST_DRAIN: begin
				state_d = ST_DSTART;
			end
			ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/swrl_datapath.sv
`timescale 1ns / 1ps
module swrl_datapath #(
	parameter int HISTORY_DEPTH = swrl_pkg::SWRL_HISTORY_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [swrl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                         cfg_data,
	input  logic                                operation,
	input  logic [swrl_pkg::TIME_W-1:0]         now_time,
	input  logic [swrl_pkg::PAYLOAD_W-1:0]      packet_bytes,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic                                send_allowed,
	output logic [31:0]                         average_rate,
	input  swrl_pkg::swrl_cmd_t                 cmd,
	output swrl_pkg::swrl_status_t              status
);

	import swrl_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int TOTAL_W = BYTES_W + $clog2(HISTORY_DEPTH);
	localparam int DCW = $clog2(TOTAL_W);
	localparam int RAM_W = BYTES_W + TIME_W;

	logic [31:0]          min_interval_q, max_rate_q;
	logic                 operation_q;
	logic [TIME_W-1:0]    now_q;
	logic [PAYLOAD_W-1:0] bytes_q;
	logic [AW-1:0]        slot_q, scan_cnt_q;
	logic [HISTORY_DEPTH-1:0] valid_q;
	logic                 rd_en_s1, rd_valid_s1;
	logic [RAM_W-1:0]     rd_data, wr_data;
	logic [BYTES_W-1:0]   rd_bytes;
	logic [TIME_W-1:0]    rd_time;
	logic [TOTAL_W-1:0]   total_q, dq_q;
	logic [TIME_W-1:0]    oldest_q, newest_q, divisor_q, rem_q, delta;
	logic [DCW-1:0]       div_cnt_q;
	logic                 interval_ok_q;
	logic [32:0]          rem_shift;
	logic                 rem_ge;
	logic                 bypass, rate_over;
	logic                 out_valid_q, send_allowed_q;
	logic [31:0]          average_rate_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q <= '0;
			max_rate_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MIN_INTERVAL: min_interval_q <= cfg_data;
				CFG_MAX_RATE:     max_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign bypass = (min_interval_q == '0) && (max_rate_q == '0);

	// captured item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			operation_q <= operation;
			now_q <= now_time;
			bytes_q <= packet_bytes;
		end
	end

	// history ring: one ram for size and time, valid bits in flops
	assign wr_data = {BYTES_W'(bytes_q) + HEADER_BYTES, now_q};

	swrl_ram #(
		.WIDTH(RAM_W),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (cmd.write_rec),
		.waddr(slot_q),
		.wdata(wr_data),
		.raddr(scan_cnt_q),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			valid_q <= '0;
			scan_cnt_q <= '0;
			rd_en_s1 <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (cmd.write_rec) begin
				valid_q[slot_q] <= 1'b1;
				slot_q <= (slot_q == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			end
			if (cmd.scan_clear) begin
				scan_cnt_q <= '0;
			end else if (cmd.scan_read) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			rd_en_s1 <= cmd.scan_read;
			rd_valid_s1 <= valid_q[scan_cnt_q];
		end
	end

	// a slot never written reads as empty
	assign rd_bytes = rd_valid_s1 ? rd_data[TIME_W +: BYTES_W] : '0;
	assign rd_time = rd_valid_s1 ? rd_data[TIME_W-1:0] : '0;

	// window sum and oldest/newest times
	always_ff @(posedge clk) begin
		if (cmd.scan_clear) begin
			total_q <= '0;
			oldest_q <= now_q;
			newest_q <= '0;
		end else if (rd_en_s1) begin
			total_q <= total_q + TOTAL_W'(rd_bytes);
			if (rd_time != '0) begin
				if (rd_time < oldest_q) begin
					oldest_q <= rd_time;
				end
				if (rd_time > newest_q) begin
					newest_q <= rd_time;
				end
			end
		end
	end

	// restoring divider, one quotient bit a cycle
	assign delta = now_q - oldest_q;
	assign rem_shift = {rem_q, dq_q[TOTAL_W-1]};
	assign rem_ge = rem_shift >= {1'b0, divisor_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			divisor_q <= (delta == '0) ? TIME_W'(1) : delta;
			rem_q <= '0;
			dq_q <= total_q;
			div_cnt_q <= '0;
			interval_ok_q <= ((now_q - newest_q) >= min_interval_q);
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? TIME_W'(rem_shift - {1'b0, divisor_q}) : rem_shift[TIME_W-1:0];
			dq_q <= {dq_q[TOTAL_W-2:0], rem_ge};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	// result register
	assign rate_over = (max_rate_q != '0) && (32'(dq_q) > max_rate_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			send_allowed_q <= bypass | (interval_ok_q & ~rate_over);
			average_rate_q <= bypass ? '0 : 32'(dq_q);
		end
	end

	assign out_valid = out_valid_q;
	assign send_allowed = send_allowed_q;
	assign average_rate = average_rate_q;

	assign status.is_record = (operation_q == OP_RECORD);
	assign status.bypass = bypass;
	assign status.scan_last = (scan_cnt_q == AW'(HISTORY_DEPTH - 1));
	assign status.div_last = (div_cnt_q == DCW'(TOTAL_W - 1));
	assign status.out_free = ~out_valid_q | ~out_stall;

endmodule

FILE: rtl/core/sliding_window_send_rate_limiter_core.sv
`timescale 1ns / 1ps
// channel   direction  handshake                  beat
// in        input      in_valid / in_stall        operation, now_time, packet_bytes
// out       output     out_valid / out_stall      send_allowed, average_rate
// cfg       input      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// a record is captured, then written to the ring; a query is captured, then
// scans the ring with one ram read per slot and divides the window sum by the time since
// the oldest record, one quotient bit a cycle; both are skipped when both limits are zero
// reset clears the limits, the slot index and the slot valid bits; no clearing pass
// a finished result waits in the output register while the next item is taken
module sliding_window_send_rate_limiter_core #(
	parameter int HISTORY_DEPTH = swrl_pkg::SWRL_HISTORY_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           operation,
	input  logic [swrl_pkg::TIME_W-1:0]    now_time,
	input  logic [swrl_pkg::PAYLOAD_W-1:0] packet_bytes,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           send_allowed,
	output logic [31:0]                    average_rate,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [swrl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	import swrl_pkg::*;

	swrl_cmd_t    cmd;
	swrl_status_t status;

	assign cfg_ready = 1'b1;

	swrl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	swrl_datapath #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid & cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.operation   (operation),
		.now_time    (now_time),
		.packet_bytes(packet_bytes),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.send_allowed(send_allowed),
		.average_rate(average_rate),
		.cmd         (cmd),
		.status      (status)
	);

endmodule
